/* hdl/held_value_round_robin_spreader_macros.svh */
// Assertion macros for the held-value round-robin spreader.
// Used by the top level only; the bodies expect clk and rst_n in scope.
`ifndef HELD_VALUE_ROUND_ROBIN_SPREADER_MACROS_SVH
`define HELD_VALUE_ROUND_ROBIN_SPREADER_MACROS_SVH
`ifndef SYNTHESIS
`define HVRRS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HVRRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HVRRS_ASSERT_SAME(label, ante, cons, msg)
`define HVRRS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* hdl/hvrrs_pkg.sv */
// Package for the held-value round-robin spreader: defaults, codes and types.
// No dependencies.
`default_nettype none
package hvrrs_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int VALUE_BITS_DEF = 16;
  localparam int OP_W           = 3;

  localparam logic KIND_TRIG  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_PRESS     = 3'd0,
    OP_RELEASE   = 3'd1,
    OP_NEXT      = 3'd2,
    OP_LATCH_ON  = 3'd3,
    OP_LATCH_OFF = 3'd4,
    OP_ENABLE    = 3'd5,
    OP_DISABLE   = 3'd6
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SHIFT,
    ST_EMIT_IN,
    ST_CLR_PEND,
    ST_PLAY,
    ST_DUMP
  } state_t;

endpackage
`default_nettype wire

/* hdl/hvrrs_if.sv */
// Input and result channel interfaces of the spreader (valid/ready words).
// Depends on hvrrs_pkg.
`default_nettype none
interface hvrrs_in_if #(
  parameter int VALUE_BITS = hvrrs_pkg::VALUE_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic [hvrrs_pkg::OP_W-1:0] opcode;
  logic [VALUE_BITS-1:0]      in_value;

  modport source (output valid, opcode, in_value, input ready);
  modport sink   (input valid, opcode, in_value, output ready);
endinterface

interface hvrrs_out_if #(
  parameter int VALUE_BITS = hvrrs_pkg::VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] out_value;
  logic                  event_kind;
  logic                  last_of_run;

  modport source (output valid, out_value, event_kind, last_of_run, input ready);
  modport sink   (input valid, out_value, event_kind, last_of_run, output ready);
endinterface
`default_nettype wire

/* hdl/hvrrs_ram.sv */
// Simple dual-port RAM, one write and one registered read per cycle.
// Depends on hvrrs_pkg for defaults.
`default_nettype none
module hvrrs_ram #(
  parameter int DEPTH = hvrrs_pkg::LIST_DEPTH_DEF,
  parameter int WIDTH = hvrrs_pkg::VALUE_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/hvrrs_seq.sv */
// Sequencer and state of the spreader: scans and shifts list entries one per
// cycle through the shared read address, and plays one entry per next tick. Depends on hvrrs_pkg.
`default_nettype none
module hvrrs_seq #(
  parameter int LIST_DEPTH = hvrrs_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_BITS = hvrrs_pkg::VALUE_BITS_DEF,
  localparam int IDX_W     = $clog2(LIST_DEPTH),
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [hvrrs_pkg::OP_W-1:0] opcode,
  input  wire logic [VALUE_BITS-1:0]      in_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [VALUE_BITS-1:0]      out_value,
  output logic                            event_kind,
  output logic                            last_of_run,
  output logic      [IDX_W-1:0]           rd_addr,
  input  wire logic [VALUE_BITS-1:0]      list_rdata,
  input  wire logic [VALUE_BITS-1:0]      held_rdata,
  output logic                            list_we,
  output logic      [IDX_W-1:0]           list_waddr,
  output logic      [VALUE_BITS-1:0]      list_wdata,
  output logic                            held_we,
  output logic      [IDX_W-1:0]           held_waddr,
  output logic      [VALUE_BITS-1:0]      held_wdata
);

  hvrrs_pkg::state_t state_r, state_nxt;

  logic [hvrrs_pkg::OP_W-1:0] op_r, op_nxt;
  logic [VALUE_BITS-1:0]      val_r, val_nxt;
  logic [IDX_W-1:0]           addr_r, addr_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [IDX_W-1:0]           pi_r, pi_nxt;
  logic [LIST_DEPTH-1:0]      hv_r, hv_nxt;
  logic [VALUE_BITS-1:0]      pend_val_r, pend_val_nxt;
  logic                       pend_vld_r, pend_vld_nxt;
  logic                       en_r, en_nxt;
  logic                       latch_r, latch_nxt;
  logic                       found_r, found_nxt;
  logic [IDX_W-1:0]           slot_r, slot_nxt;
  logic                       slot_ok_r, slot_ok_nxt;
  logic                       lmatch_r, lmatch_nxt;
  logic [IDX_W-1:0]           mi_r, mi_nxt;
  logic                       ov_r, ov_nxt;
  logic [VALUE_BITS-1:0]      oval_r, oval_nxt;
  logic                       okind_r, okind_nxt;
  logic                       olast_r, olast_nxt;

  logic             out_free;
  logic             held_empty;
  logic             has_play;
  logic [IDX_W-1:0] play_addr;
  logic             scan_end;
  logic             addr_last;
  logic             hmatch;
  logic             lm_hit;
  logic             slot_hit;
  logic             found_c;
  logic             slot_ok_c;
  logic [IDX_W-1:0] slot_c;
  logic             lmatch_c;
  logic [IDX_W-1:0] mi_c;
  logic [CNT_W-1:0] addr_inc;

  function automatic logic [IDX_W-1:0] fix_index(
    input logic [IDX_W-1:0] pi,
    input logic [IDX_W-1:0] mi,
    input logic [CNT_W-1:0] cnt_new
  );
    logic [IDX_W-1:0] p;
    p = (pi > mi) ? pi - 1'b1 : pi;
    if (CNT_W'(p) >= cnt_new) begin
      p = '0;
    end
    return p;
  endfunction

  assign out_free   = !ov_r || out_ready;
  assign held_empty = ~|hv_r;
  assign has_play   = (latch_r || !held_empty) && (cnt_r != '0);
  assign play_addr  = (CNT_W'(pi_r) >= cnt_r) ? '0 : pi_r;
  assign addr_inc   = CNT_W'(addr_r) + 1'b1;
  assign addr_last  = (addr_inc == cnt_r);
  assign scan_end   = (addr_r == IDX_W'(LIST_DEPTH - 1));

  // compares against the captured word
  assign hmatch    = hv_r[addr_r] && (held_rdata == val_r);
  assign lm_hit    = !latch_r && !lmatch_r && (CNT_W'(addr_r) < cnt_r)
                     && (list_rdata == val_r);
  assign slot_hit  = !hv_r[addr_r] && !slot_ok_r;
  assign found_c   = found_r | hmatch;
  assign slot_ok_c = slot_ok_r | slot_hit;
  assign slot_c    = slot_hit ? addr_r : slot_r;
  assign lmatch_c  = lmatch_r | lm_hit;
  assign mi_c      = lm_hit ? addr_r : mi_r;

  assign in_ready    = (state_r == hvrrs_pkg::ST_IDLE);
  assign out_valid   = ov_r;
  assign out_value   = oval_r;
  assign event_kind  = okind_r;
  assign last_of_run = olast_r;
  assign rd_addr     = addr_nxt;
  assign held_wdata  = val_r;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    val_nxt      = val_r;
    addr_nxt     = addr_r;
    cnt_nxt      = cnt_r;
    pi_nxt       = pi_r;
    hv_nxt       = hv_r;
    pend_val_nxt = pend_val_r;
    pend_vld_nxt = pend_vld_r;
    en_nxt       = en_r;
    latch_nxt    = latch_r;
    found_nxt    = found_r;
    slot_nxt     = slot_r;
    slot_ok_nxt  = slot_ok_r;
    lmatch_nxt   = lmatch_r;
    mi_nxt       = mi_r;
    ov_nxt       = ov_r && !out_ready;
    oval_nxt     = oval_r;
    okind_nxt    = okind_r;
    olast_nxt    = olast_r;
    list_we      = 1'b0;
    list_waddr   = addr_r;
    list_wdata   = val_r;
    held_we      = 1'b0;
    held_waddr   = slot_c;

    unique case (state_r)
      hvrrs_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = opcode;
          val_nxt   = in_value;
          state_nxt = hvrrs_pkg::ST_DECODE;
        end
      end

      hvrrs_pkg::ST_DECODE: begin
        state_nxt = hvrrs_pkg::ST_IDLE;
        case (op_r)
          hvrrs_pkg::OP_PRESS: begin
            if (!en_r) begin
              state_nxt = hvrrs_pkg::ST_EMIT_IN;
            end else if (held_empty) begin
              cnt_nxt     = '0;
              pi_nxt      = '0;
              addr_nxt    = '0;
              found_nxt   = 1'b0;
              slot_ok_nxt = 1'b0;
              state_nxt   = hvrrs_pkg::ST_SCAN;
            end else if (cnt_r != CNT_W'(LIST_DEPTH)) begin
              addr_nxt    = '0;
              found_nxt   = 1'b0;
              slot_ok_nxt = 1'b0;
              state_nxt   = hvrrs_pkg::ST_SCAN;
            end
          end
          hvrrs_pkg::OP_RELEASE: begin
            if (!en_r) begin
              state_nxt = hvrrs_pkg::ST_EMIT_IN;
            end else begin
              addr_nxt   = '0;
              lmatch_nxt = 1'b0;
              state_nxt  = hvrrs_pkg::ST_SCAN;
            end
          end
          hvrrs_pkg::OP_NEXT: begin
            if (en_r) begin
              if (pend_vld_r) begin
                state_nxt = hvrrs_pkg::ST_CLR_PEND;
              end else if (has_play) begin
                addr_nxt  = play_addr;
                state_nxt = hvrrs_pkg::ST_PLAY;
              end
            end
          end
          hvrrs_pkg::OP_LATCH_ON: begin
            latch_nxt = 1'b1;
          end
          hvrrs_pkg::OP_LATCH_OFF, hvrrs_pkg::OP_DISABLE: begin
            if (op_r == hvrrs_pkg::OP_LATCH_OFF) begin
              latch_nxt = 1'b0;
            end else begin
              en_nxt = 1'b0;
            end
            if (cnt_r == '0) begin
              pi_nxt       = '0;
              hv_nxt       = '0;
              pend_vld_nxt = 1'b0;
              pend_val_nxt = '0;
            end else begin
              addr_nxt  = '0;
              state_nxt = hvrrs_pkg::ST_DUMP;
            end
          end
          hvrrs_pkg::OP_ENABLE: begin
            en_nxt       = 1'b1;
            cnt_nxt      = '0;
            pi_nxt       = '0;
            hv_nxt       = '0;
            pend_vld_nxt = 1'b0;
            pend_val_nxt = '0;
          end
          default: begin
          end
        endcase
      end

      hvrrs_pkg::ST_SCAN: begin
        if (op_r == hvrrs_pkg::OP_PRESS) begin
          found_nxt   = found_c;
          slot_nxt    = slot_c;
          slot_ok_nxt = slot_ok_c;
          if (scan_end) begin
            if (!found_c && slot_ok_c) begin
              held_we        = 1'b1;
              hv_nxt[slot_c] = 1'b1;
            end
            list_we    = 1'b1;
            list_waddr = cnt_r[IDX_W-1:0];
            cnt_nxt    = cnt_r + 1'b1;
            state_nxt  = hvrrs_pkg::ST_IDLE;
          end
        end else begin
          if (hmatch) begin
            hv_nxt[addr_r] = 1'b0;
          end
          lmatch_nxt = lmatch_c;
          mi_nxt     = mi_c;
          if (scan_end) begin
            state_nxt = hvrrs_pkg::ST_IDLE;
            if (lmatch_c) begin
              if (CNT_W'(mi_c) + 1'b1 == cnt_r) begin
                cnt_nxt = cnt_r - 1'b1;
                pi_nxt  = fix_index(pi_r, mi_c, CNT_W'(cnt_r - 1'b1));
              end else begin
                addr_nxt  = mi_c + 1'b1;
                state_nxt = hvrrs_pkg::ST_SHIFT;
              end
            end
          end
        end
        if (!scan_end) begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      hvrrs_pkg::ST_SHIFT: begin
        list_we    = 1'b1;
        list_waddr = addr_r - 1'b1;
        list_wdata = list_rdata;
        if (addr_last) begin
          cnt_nxt   = cnt_r - 1'b1;
          pi_nxt    = fix_index(pi_r, mi_r, CNT_W'(cnt_r - 1'b1));
          state_nxt = hvrrs_pkg::ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      hvrrs_pkg::ST_EMIT_IN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oval_nxt  = val_r;
          okind_nxt = (op_r == hvrrs_pkg::OP_RELEASE) ? hvrrs_pkg::KIND_CLEAR
                                                       : hvrrs_pkg::KIND_TRIG;
          olast_nxt = 1'b1;
          state_nxt = hvrrs_pkg::ST_IDLE;
        end
      end

      hvrrs_pkg::ST_CLR_PEND: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          oval_nxt     = pend_val_r;
          okind_nxt    = hvrrs_pkg::KIND_CLEAR;
          olast_nxt    = !has_play;
          pend_vld_nxt = 1'b0;
          pend_val_nxt = '0;
          if (has_play) begin
            addr_nxt  = play_addr;
            state_nxt = hvrrs_pkg::ST_PLAY;
          end else begin
            state_nxt = hvrrs_pkg::ST_IDLE;
          end
        end
      end

      hvrrs_pkg::ST_PLAY: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          oval_nxt     = list_rdata;
          okind_nxt    = hvrrs_pkg::KIND_TRIG;
          olast_nxt    = 1'b1;
          pend_val_nxt = list_rdata;
          pend_vld_nxt = 1'b1;
          pi_nxt       = (addr_inc >= cnt_r) ? '0 : IDX_W'(addr_inc);
          state_nxt    = hvrrs_pkg::ST_IDLE;
        end
      end

      hvrrs_pkg::ST_DUMP: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oval_nxt  = list_rdata;
          okind_nxt = hvrrs_pkg::KIND_CLEAR;
          olast_nxt = addr_last;
          if (addr_last) begin
            cnt_nxt      = '0;
            pi_nxt       = '0;
            hv_nxt       = '0;
            pend_vld_nxt = 1'b0;
            pend_val_nxt = '0;
            state_nxt    = hvrrs_pkg::ST_IDLE;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= hvrrs_pkg::ST_IDLE;
      cnt_r      <= '0;
      pi_r       <= '0;
      hv_r       <= '0;
      pend_val_r <= '0;
      pend_vld_r <= 1'b0;
      en_r       <= 1'b1;
      latch_r    <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pi_r       <= pi_nxt;
      hv_r       <= hv_nxt;
      pend_val_r <= pend_val_nxt;
      pend_vld_r <= pend_vld_nxt;
      en_r       <= en_nxt;
      latch_r    <= latch_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    addr_r    <= addr_nxt;
    found_r   <= found_nxt;
    slot_r    <= slot_nxt;
    slot_ok_r <= slot_ok_nxt;
    lmatch_r  <= lmatch_nxt;
    mi_r      <= mi_nxt;
    oval_r    <= oval_nxt;
    okind_r   <= okind_nxt;
    olast_r   <= olast_nxt;
  end

endmodule
`default_nettype wire

/* hdl/held_value_round_robin_spreader.sv */
// Top level of the held-value round-robin spreader.
// Depends on hvrrs_pkg, hvrrs_if, hvrrs_ram, hvrrs_seq and the macros header.
//
// One word is taken at a time; in_ready is high only when the block is idle.
// A press or release sweeps the held-word and list memories one entry per
// cycle through the read address that they share; a press onto a full list
// is dropped. A release that removes a list entry then shifts each entry
// behind it down one place. A next tick clears the pending word and plays
// the next entry; latch off or disable dumps the list, each entry giving one
// clear. Results leave through a one-word output register, so a finished
// word may wait there while the next input word is taken. Press and release
// words pass straight through while disabled. There is no clearing pass
// after reset.
`default_nettype none
`include "held_value_round_robin_spreader_macros.svh"
module held_value_round_robin_spreader #(
  parameter int LIST_DEPTH = hvrrs_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_BITS = hvrrs_pkg::VALUE_BITS_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  hvrrs_in_if.sink    in_ch,
  hvrrs_out_if.source out_ch
);

  localparam int IDX_W = $clog2(LIST_DEPTH);

  logic [IDX_W-1:0]      rd_addr;
  logic [VALUE_BITS-1:0] list_rdata;
  logic [VALUE_BITS-1:0] held_rdata;
  logic                  list_we;
  logic [IDX_W-1:0]      list_waddr;
  logic [VALUE_BITS-1:0] list_wdata;
  logic                  held_we;
  logic [IDX_W-1:0]      held_waddr;
  logic [VALUE_BITS-1:0] held_wdata;

  hvrrs_seq #(
    .LIST_DEPTH (LIST_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .opcode      (in_ch.opcode),
    .in_value    (in_ch.in_value),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_value   (out_ch.out_value),
    .event_kind  (out_ch.event_kind),
    .last_of_run (out_ch.last_of_run),
    .rd_addr     (rd_addr),
    .list_rdata  (list_rdata),
    .held_rdata  (held_rdata),
    .list_we     (list_we),
    .list_waddr  (list_waddr),
    .list_wdata  (list_wdata),
    .held_we     (held_we),
    .held_waddr  (held_waddr),
    .held_wdata  (held_wdata)
  );

  hvrrs_ram #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (VALUE_BITS)
  ) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (rd_addr),
    .rdata (list_rdata)
  );

  hvrrs_ram #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (VALUE_BITS)
  ) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_waddr),
    .wdata (held_wdata),
    .raddr (rd_addr),
    .rdata (held_rdata)
  );

  `HVRRS_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "still ready")
  `HVRRS_ASSERT_SAME(a_no_write_idle, in_ch.ready, !list_we && !held_we, "memory write while idle")
  `HVRRS_ASSERT_SAME(a_held_with_list, held_we, list_we, "held insert without list append")

endmodule
`default_nettype wire

/* bench/spread_checker.sv */
// Checker for the held-value round-robin spreader: watches the input and result
// channels, predicts every result word and compares it field by field.
// Depends on hvrrs_pkg and hvrrs_if.
module spread_checker #(
  parameter int LIST_DEPTH = hvrrs_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_BITS = hvrrs_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hvrrs_in_if         in_mon,
  hvrrs_out_if        out_mon,
  output int unsigned fail_count,
  output int unsigned words_owed,
  output int unsigned words_in,
  output int unsigned words_out,
  output int unsigned clears_out
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  kind;
    logic                  last;
  } spread_word_t;

  logic [VALUE_BITS-1:0] list_q [LIST_DEPTH];
  int unsigned           list_len;
  int unsigned           play_ptr;
  logic [VALUE_BITS-1:0] held_q [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] held_v;
  logic [VALUE_BITS-1:0] pend_value;
  bit                    pend_v;
  bit                    enabled;
  bit                    latched;

  spread_word_t owed_words[$];
  spread_word_t run_words[$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    fail_count++;
    $display("%0t spreader mismatch (%s): got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic clear_tracking();
    list_len   = 0;
    play_ptr   = 0;
    held_v     = '0;
    pend_value = '0;
    pend_v     = 1'b0;
  endtask

  task automatic add_word(input logic [VALUE_BITS-1:0] v, input logic kind);
    spread_word_t w;
    w.value = v;
    w.kind  = kind;
    w.last  = 1'b0;
    run_words = {run_words, w};
  endtask

  task automatic flush_list();
    for (int i = 0; i < list_len; i++)
      add_word(list_q[i], hvrrs_pkg::KIND_CLEAR);
    clear_tracking();
  endtask

  task automatic press_word(input logic [VALUE_BITS-1:0] v);
    bit          found;
    int unsigned slot;
    if (held_v == '0) begin
      list_len = 0;
      play_ptr = 0;
    end
    if (list_len >= LIST_DEPTH) return;
    found = 1'b0;
    slot  = LIST_DEPTH;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (held_v[i] && held_q[i] == v) found = 1'b1;
      else if (!held_v[i] && slot == LIST_DEPTH) slot = i;
    end
    if (!found && slot < LIST_DEPTH) begin
      held_q[slot] = v;
      held_v[slot] = 1'b1;
    end
    list_q[list_len] = v;
    list_len++;
  endtask

  task automatic release_word(input logic [VALUE_BITS-1:0] v);
    int hit;
    for (int i = 0; i < LIST_DEPTH; i++)
      if (held_v[i] && held_q[i] == v) held_v[i] = 1'b0;
    if (latched) return;
    hit = -1;
    for (int i = 0; i < list_len; i++)
      if (hit < 0 && list_q[i] == v) hit = i;
    if (hit < 0) return;
    for (int j = hit; j + 1 < list_len; j++)
      list_q[j] = list_q[j+1];
    list_len--;
    if (play_ptr > hit) play_ptr--;
    if (play_ptr >= list_len) play_ptr = 0;
  endtask

  task automatic tick_word();
    if (pend_v) begin
      add_word(pend_value, hvrrs_pkg::KIND_CLEAR);
      pend_v     = 1'b0;
      pend_value = '0;
    end
    if ((latched || held_v != '0) && list_len > 0) begin
      if (play_ptr >= list_len) play_ptr = 0;
      pend_value = list_q[play_ptr];
      pend_v     = 1'b1;
      add_word(pend_value, hvrrs_pkg::KIND_TRIG);
      play_ptr++;
      if (play_ptr >= list_len) play_ptr = 0;
    end
  endtask

  task automatic predict_event(input logic [hvrrs_pkg::OP_W-1:0] op,
                               input logic [VALUE_BITS-1:0] v);
    run_words.delete();
    case (hvrrs_pkg::opcode_t'(op))
      hvrrs_pkg::OP_PRESS: begin
        if (enabled) press_word(v);
        else add_word(v, hvrrs_pkg::KIND_TRIG);
      end
      hvrrs_pkg::OP_RELEASE: begin
        if (enabled) release_word(v);
        else add_word(v, hvrrs_pkg::KIND_CLEAR);
      end
      hvrrs_pkg::OP_NEXT: begin
        if (enabled) tick_word();
      end
      hvrrs_pkg::OP_LATCH_ON: latched = 1'b1;
      hvrrs_pkg::OP_LATCH_OFF: begin
        latched = 1'b0;
        flush_list();
      end
      hvrrs_pkg::OP_ENABLE: begin
        clear_tracking();
        enabled = 1'b1;
      end
      hvrrs_pkg::OP_DISABLE: begin
        flush_list();
        enabled = 1'b0;
      end
      default: ;
    endcase
    if (run_words.size() > 0) run_words[run_words.size()-1].last = 1'b1;
    owed_words = {owed_words, run_words};
  endtask

  task automatic check_word();
    spread_word_t want;
    words_out++;
    if (out_mon.event_kind == hvrrs_pkg::KIND_CLEAR) clears_out++;
    if (owed_words.size() == 0) begin
      report("unexpected result word", 64'(out_mon.out_value), '0);
      return;
    end
    want = owed_words.pop_front();
    if (out_mon.out_value !== want.value)
      report("out_value", 64'(out_mon.out_value), 64'(want.value));
    if (out_mon.event_kind !== want.kind)
      report("event_kind", 64'(out_mon.event_kind), 64'(want.kind));
    if (out_mon.last_of_run !== want.last)
      report("last_of_run", 64'(out_mon.last_of_run), 64'(want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tracking();
      enabled = 1'b1;
      latched = 1'b0;
      owed_words.delete();
      fail_count = 0;
      words_in   = 0;
      words_out  = 0;
      clears_out = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_word();
      if (in_mon.valid && in_mon.ready) begin
        words_in++;
        predict_event(in_mon.opcode, in_mon.in_value);
      end
    end
    words_owed = owed_words.size();
  end

endmodule

/* bench/tb_top.sv */
// Testbench top for the held-value round-robin spreader: clock, reset, event
// stimulus with random gaps and result back-pressure, and the verdict.
// Depends on hvrrs_pkg, hvrrs_if, spread_checker and the spreader RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH          = hvrrs_pkg::LIST_DEPTH_DEF;
  localparam int          VB             = hvrrs_pkg::VALUE_BITS_DEF;
  localparam int unsigned DIRECTED_WORDS = 28;
  localparam int unsigned RANDOM_WORDS   = 125;
  localparam int unsigned SETTLE_CYCLES  = 4 * DEPTH;
  localparam int unsigned CYCLE_LIMIT    = 1000000;

  logic        clk;
  logic        rst_n;
  int unsigned sent;
  int unsigned cycles;
  bit          steady;
  int unsigned fail_count, words_owed, words_in, words_out, clears_out;

  hvrrs_in_if  #(.VALUE_BITS(VB)) in_ch ();
  hvrrs_out_if #(.VALUE_BITS(VB)) out_ch ();

  held_value_round_robin_spreader #(
    .LIST_DEPTH(DEPTH),
    .VALUE_BITS(VB)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  spread_checker #(
    .LIST_DEPTH(DEPTH),
    .VALUE_BITS(VB)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(fail_count),
    .words_owed(words_owed),
    .words_in  (words_in),
    .words_out (words_out),
    .clears_out(clears_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [VB-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return VB'($urandom());
    endcase
  endfunction

  task automatic send_event(input hvrrs_pkg::opcode_t op, input logic [VB-1:0] v);
    int unsigned gap;
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.in_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    gap = (steady || $urandom_range(0, 1)) ? 0 : pause_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (words_owed == 0);
  endtask

  task automatic play_chord(input bit latched);
    logic [VB-1:0] keys[$];
    logic [VB-1:0] w;
    int unsigned   idx;
    if (latched) send_event(hvrrs_pkg::OP_LATCH_ON, pick_word());
    repeat ($urandom_range(1, 6)) begin
      w = (keys.size() > 0 && $urandom_range(0, 4) == 0) ? keys[0] : pick_word();
      keys = {keys, w};
      send_event(hvrrs_pkg::OP_PRESS, w);
      if ($urandom_range(0, 2) == 0) send_event(hvrrs_pkg::OP_NEXT, pick_word());
    end
    repeat ($urandom_range(1, 6)) send_event(hvrrs_pkg::OP_NEXT, pick_word());
    while (keys.size() > 0) begin
      idx = $urandom_range(0, keys.size() - 1);
      send_event(hvrrs_pkg::OP_RELEASE, keys[idx]);
      keys.delete(idx);
      if ($urandom_range(0, 1)) send_event(hvrrs_pkg::OP_NEXT, pick_word());
    end
    if (latched) begin
      repeat ($urandom_range(0, 4)) send_event(hvrrs_pkg::OP_NEXT, pick_word());
      send_event(hvrrs_pkg::OP_LATCH_OFF, pick_word());
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      case ($urandom_range(0, 9))
        0: begin
          out_ch.ready <= 1'b1;
          repeat ($urandom_range(50, 200)) @(posedge clk);
        end
        1, 2, 3: begin
          out_ch.ready <= 1'b0;
          repeat (pause_len()) @(posedge clk);
        end
        default: begin
          out_ch.ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      endcase
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped after %0d cycles, %0d result words still expected",
             cycles, words_owed);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned   n;
    bit            paused;
    logic [VB-1:0] w;
    logic [VB-1:0] pool[$];
    paused = 1'b0;
    sent   = 0;
    steady = 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= hvrrs_pkg::OP_PRESS;
    in_ch.in_value <= '0;
    rst_n          <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, duplicates, release fix-up, latch, bypass, enable with pending word
    send_event(hvrrs_pkg::OP_PRESS, '0);
    send_event(hvrrs_pkg::OP_PRESS, '1);
    send_event(hvrrs_pkg::OP_PRESS, '1);
    send_event(hvrrs_pkg::OP_NEXT, '0);
    send_event(hvrrs_pkg::OP_NEXT, 16'h5555);
    send_event(hvrrs_pkg::OP_RELEASE, 16'h1234);
    send_event(hvrrs_pkg::OP_RELEASE, '0);
    send_event(hvrrs_pkg::OP_NEXT, '0);
    send_event(hvrrs_pkg::OP_LATCH_ON, '0);
    send_event(hvrrs_pkg::OP_RELEASE, '1);
    send_event(hvrrs_pkg::OP_NEXT, '0);
    send_event(hvrrs_pkg::OP_PRESS, 16'hA5A5);
    send_event(hvrrs_pkg::OP_LATCH_OFF, '0);
    send_event(hvrrs_pkg::OP_NEXT, '0);
    send_event(hvrrs_pkg::OP_DISABLE, '0);
    send_event(hvrrs_pkg::OP_PRESS, 16'h5A5A);
    send_event(hvrrs_pkg::OP_RELEASE, 16'h5A5A);
    send_event(hvrrs_pkg::OP_NEXT, '0);
    send_event(hvrrs_pkg::OP_LATCH_ON, '0);
    send_event(hvrrs_pkg::OP_LATCH_OFF, '0);
    send_event(hvrrs_pkg::OP_ENABLE, '0);
    send_event(hvrrs_pkg::OP_PRESS, 16'h0F0F);
    send_event(hvrrs_pkg::OP_NEXT, '0);
    send_event(hvrrs_pkg::OP_ENABLE, '0);
    send_event(hvrrs_pkg::OP_PRESS, 16'hF0F0);
    send_event(hvrrs_pkg::OP_PRESS, 16'h8001);
    send_event(hvrrs_pkg::OP_DISABLE, '0);
    send_event(hvrrs_pkg::OP_ENABLE, '0);
    drain();

    while (sent < DIRECTED_WORDS + RANDOM_WORDS) begin
      steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(0, 99);
      if (n < 45) begin
        play_chord(1'b0);
      end else if (n < 60) begin
        play_chord(1'b1);
      end else if (n < 67) begin
        // overfill: presses past the list depth are dropped
        pool.delete();
        repeat ($urandom_range(DEPTH, DEPTH + 2)) begin
          w = pick_word();
          pool = {pool, w};
          send_event(hvrrs_pkg::OP_PRESS, w);
        end
        repeat ($urandom_range(2, 20)) send_event(hvrrs_pkg::OP_NEXT, pick_word());
        if ($urandom_range(0, 1)) begin
          send_event(hvrrs_pkg::OP_DISABLE, pick_word());
          send_event(hvrrs_pkg::OP_ENABLE, pick_word());
        end else begin
          foreach (pool[i]) begin
            send_event(hvrrs_pkg::OP_RELEASE, pool[i]);
            if ($urandom_range(0, 2) == 0) send_event(hvrrs_pkg::OP_NEXT, pick_word());
          end
        end
      end else if (n < 79) begin
        send_event(hvrrs_pkg::OP_DISABLE, pick_word());
        repeat ($urandom_range(1, 5)) begin
          n = $urandom_range(0, 3);
          send_event(n == 0 ? hvrrs_pkg::OP_PRESS :
                     n == 1 ? hvrrs_pkg::OP_RELEASE :
                     n == 2 ? hvrrs_pkg::OP_NEXT : hvrrs_pkg::OP_LATCH_ON,
                     pick_word());
        end
        if ($urandom_range(0, 1)) send_event(hvrrs_pkg::OP_LATCH_OFF, pick_word());
        send_event(hvrrs_pkg::OP_ENABLE, pick_word());
      end else begin
        repeat ($urandom_range(1, 6))
          send_event(hvrrs_pkg::opcode_t'($urandom_range(hvrrs_pkg::OP_PRESS,
                                                         hvrrs_pkg::OP_DISABLE)),
                     pick_word());
      end
      if (!paused && sent >= DIRECTED_WORDS + RANDOM_WORDS / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d input words and %0d result words (%0d clears) over chords,",
             words_in, words_out, clears_out);
    $display("latched runs, list overfill, disabled pass-through and random noise");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
